// ----- rtl/aes_pkg.sv -----
package aes_pkg;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} out_beat_t;

	localparam int unsigned NUM_ROUNDS = 10;

	typedef enum logic [0:0] {
		CFG_KEY_HIGH = 1'b0,
		CFG_KEY_LOW  = 1'b1
	} cfg_index_t;

	localparam logic [7:0] RCON [NUM_ROUNDS] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// ShiftRows: output byte j takes input byte SHIFT_SRC[j]
	localparam logic [3:0] SHIFT_SRC [16] = '{
		4'd0, 4'd5, 4'd10, 4'd15, 4'd4, 4'd9, 4'd14, 4'd3,
		4'd8, 4'd13, 4'd2, 4'd7, 4'd12, 4'd1, 4'd6, 4'd11
	};

	// byte i of a 128-bit big-endian word
	function automatic logic [7:0] byte_of(input logic [127:0] w, input int unsigned i);
		byte_of = w[127 - 8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] next_round_key(input logic [127:0] k,
			input logic [7:0] rc);
		logic [31:0] t;
		logic [127:0] q;
		t = {SBOX[byte_of(k, 13)] ^ rc, SBOX[byte_of(k, 14)],
			SBOX[byte_of(k, 15)], SBOX[byte_of(k, 12)]};
		q[127:96] = k[127:96] ^ t;
		q[95:64]  = k[95:64] ^ q[127:96];
		q[63:32]  = k[63:32] ^ q[95:64];
		q[31:0]   = k[31:0] ^ q[63:32];
		next_round_key = q;
	endfunction

endpackage

// ----- rtl/aes_round_cell.sv -----
// One cipher round plus its round-key step; registered output.
module aes_round_cell #(
	parameter logic [7:0] RC         = 8'h01,
	parameter bit         LAST_ROUND = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld_in,
	input  logic [127:0] st_in,
	input  logic [127:0] key_in,
	output logic         vld_out,
	output logic [127:0] st_out,
	output logic [127:0] key_out
);

	logic [127:0] rk;
	logic [127:0] sb;
	logic [127:0] mc;

	assign rk = aes_pkg::next_round_key(key_in, RC);

	always_comb begin
		logic [7:0] a0, a1, a2, a3;
		for (int j = 0; j < 16; j++) begin
			sb[127 - 8*j -: 8] = aes_pkg::SBOX[aes_pkg::byte_of(st_in,
				int'(aes_pkg::SHIFT_SRC[j]))];
		end
		mc = sb;
		if (!LAST_ROUND) begin
			for (int c = 0; c < 4; c++) begin
				a0 = sb[127 - 32*c -: 8];
				a1 = sb[119 - 32*c -: 8];
				a2 = sb[111 - 32*c -: 8];
				a3 = sb[103 - 32*c -: 8];
				mc[127 - 32*c -: 8] = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
				mc[119 - 32*c -: 8] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
				mc[111 - 32*c -: 8] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
				mc[103 - 32*c -: 8] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out  <= mc ^ rk;
			key_out <= rk;
		end
	end

endmodule

// ----- rtl/aes128_block_encrypt_core.sv -----
// AES-128 encryption engine (FIPS-197). A chain of ten round cells, each
// holding one block and its round key, passes data one cell onward every
// cycle unless stalled. One 128-bit block is accepted per clock while the
// chain is not stalled. The accepting edge loads the input AddRoundKey
// register; the block then moves through the ten round cells to the output.
// The key travels with each block, so a key written between blocks
// applies from the next accepted block. out_stall freezes the whole
// chain while out_valid is high; in_stall simply follows it. Bytes are
// big-endian: byte 0 sits in bits 63:56 of the high half. Config index
// 0 is key_high, 1 is key_low.
module aes128_block_encrypt_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  aes_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output aes_pkg::out_beat_t out_data
);

	localparam int unsigned N = aes_pkg::NUM_ROUNDS;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic        en;

	logic         vld [N+1];
	logic [127:0] st  [N+1];
	logic [127:0] key [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (aes_pkg::cfg_index_t'(cfg_index))
				aes_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				aes_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole chain advances unless a valid result is stalled at the output
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage zero: initial AddRoundKey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0]  <= {in_data.plain_high, in_data.plain_low} ^ {key_high_q, key_low_q};
			key[0] <= {key_high_q, key_low_q};
		end
	end

	for (genvar r = 0; r < N; r++) begin : g_round
		aes_round_cell #(
			.RC        (aes_pkg::RCON[r]),
			.LAST_ROUND(r == N - 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (vld[r]),
			.st_in  (st[r]),
			.key_in (key[r]),
			.vld_out(vld[r+1]),
			.st_out (st[r+1]),
			.key_out(key[r+1])
		);
	end

	assign out_valid            = vld[N];
	assign out_data.cipher_high = st[N][127:64];
	assign out_data.cipher_low  = st[N][63:0];

`ifndef SYNTHESIS
	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// an accepted beat enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld[0])
		else $error("accepted beat lost");

	// input is refused only while output is stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("spurious input stall");
`endif

endmodule

// ----- bench/aes128_encrypt_checker.sv -----
module aes128_encrypt_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  aes_pkg::in_beat_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  aes_pkg::out_beat_t out_data,
	output int                 fail_count,
	output int                 pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] SUB [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};
	localparam logic [7:0] RC [10] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};
	localparam int SHIFT_PERM [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};

	typedef logic [7:0] blk_bytes_t [16];

	logic [63:0]        key_hi_q, key_lo_q;
	aes_pkg::out_beat_t cipher_q [$];

	function automatic logic [7:0] dbl(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic aes_pkg::out_beat_t encrypt_block(input logic [127:0] key,
			input logic [127:0] pt);
		blk_bytes_t k, s, t;
		logic [7:0] w [4];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) begin
			k[i] = key[127-8*i -: 8];
			s[i] = pt[127-8*i -: 8] ^ k[i];
		end
		for (int r = 0; r < 10; r++) begin
			// next round key
			w[0] = SUB[k[13]] ^ RC[r];
			w[1] = SUB[k[14]];
			w[2] = SUB[k[15]];
			w[3] = SUB[k[12]];
			for (int i = 0; i < 4; i++)
				k[i] = k[i] ^ w[i];
			for (int i = 4; i < 16; i++)
				k[i] = k[i] ^ k[i-4];
			for (int i = 0; i < 16; i++)
				t[i] = SUB[s[SHIFT_PERM[i]]];
			if (r != 9) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					t[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
					t[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
					t[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
					t[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
				end
			end
			for (int i = 0; i < 16; i++)
				s[i] = t[i] ^ k[i];
		end
		for (int i = 0; i < 16; i++)
			res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		aes_pkg::out_beat_t want;
		if (!arst_n) begin
			key_hi_q      <= '0;
			key_lo_q      <= '0;
			fail_count    <= 0;
			pending_count <= 0;
			cipher_q.delete();
		end else begin
			// key is sampled with the beat it applies to, write lands after
			if (in_valid && !in_stall)
				cipher_q.push_back(encrypt_block({key_hi_q, key_lo_q}, in_data));
			if (cfg_we) begin
				case (aes_pkg::cfg_index_t'(cfg_index))
					aes_pkg::CFG_KEY_HIGH: key_hi_q <= cfg_data;
					aes_pkg::CFG_KEY_LOW:  key_lo_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected result beat %h", out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = cipher_q.pop_front();
					if (out_data.cipher_high !== want.cipher_high) begin
						$error("cipher_high: expected %h, got %h",
							want.cipher_high, out_data.cipher_high);
						fail_count <= fail_count + 1;
					end else if (out_data.cipher_low !== want.cipher_low) begin
						$error("cipher_low: expected %h, got %h",
							want.cipher_low, out_data.cipher_low);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= cipher_q.size();
		end
	end
endmodule

// ----- bench/tb_aes128_block_encrypt_core.sv -----
// Stimulus and verdict for the AES-128 encryption pipeline. Prediction and
// comparison live in the checker; this top drives keys, plaintext beats
// and the receiver stall, and decides pass or fail.
module tb_aes128_block_encrypt_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT   = 11;
	localparam int RAND_BEATS = 600;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_index;
	logic [63:0] cfg_data;
	logic      in_valid;
	logic      in_stall;
	aes_pkg::in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	aes_pkg::out_beat_t out_data;
	int        fail_count;
	int        pending_count;
	bit        hold_off;     // long receiver hold-off requested

	aes128_block_encrypt_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	aes128_encrypt_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// safety net: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: mixes stall-free stretches, random stalls and one long hold-off
	initial begin
		int mode;
		bit held;
		out_stall = 1'b0;
		mode = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				for (int i = 0; i < 60; i++)
					@(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if ($urandom_range(0, 31) == 0)
					mode = $urandom_range(0, 2);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	// one key write, then a pause with cfg_we low; only called while the pipe is empty
	task automatic write_key(input aes_pkg::cfg_index_t idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// drain everything in flight, then let the pipe settle
	task automatic drain_pipe();
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// present one beat and hold it until taken; valid stays high across
	// back-to-back beats, so no low/high pair in one step
	task automatic send_beat(input logic [63:0] hi, input logic [63:0] lo);
		in_valid <= 1'b1;
		in_data  <= '{plain_high: hi, plain_low: lo};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] edge_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'h0000_0000_0000_0001;
			4: return {32{2'b10}};
			default: return rand64();
		endcase
	endfunction

	initial begin
		int burst;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = aes_pkg::CFG_KEY_HIGH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		hold_off  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key (all zero), extremes of the plaintext
		send_beat('0, '0);
		send_beat('1, '1);
		send_beat(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
		idle_gap(0);
		drain_pipe();

		// FIPS-197 appendix C.1 vector
		write_key(aes_pkg::CFG_KEY_HIGH, 64'h0001_0203_0405_0607);
		write_key(aes_pkg::CFG_KEY_LOW,  64'h0809_0a0b_0c0d_0e0f);
		send_beat(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
		// a second plaintext under the same key
		send_beat(64'h3243_f6a8_885a_308d, 64'h3132_9876_98a2_e037);
		idle_gap(0);
		drain_pipe();

		// all-ones key, then one half changed on its own
		write_key(aes_pkg::CFG_KEY_HIGH, '1);
		write_key(aes_pkg::CFG_KEY_LOW,  '1);
		send_beat('0, '0);
		send_beat('1, '1);
		send_beat(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		idle_gap(0);
		drain_pipe();
		write_key(aes_pkg::CFG_KEY_LOW, '0);
		send_beat('1, '0);
		send_beat('0, '1);
		idle_gap(0);
		drain_pipe();

		// long hold-off while the sender keeps pushing: pipe fills, input stalls
		hold_off = 1'b1;
		for (int i = 0; i < 40; i++)
			send_beat(rand64(), rand64());
		idle_gap(0);
		drain_pipe();

		// random phases: new key each phase, bursty sender
		for (int ph = 0; ph < 7; ph++) begin
			write_key(aes_pkg::CFG_KEY_HIGH, ph == 0 ? 64'h0 : edge_word());
			write_key(aes_pkg::CFG_KEY_LOW,
				ph == 6 ? 64'hffff_ffff_ffff_ffff : edge_word());
			for (int n = 0; n < RAND_BEATS / 7; ) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst; b++) begin
					if ($urandom_range(0, 7) == 0)
						send_beat(edge_word(), edge_word());
					else
						send_beat(rand64(), rand64());
					n++;
				end
				if ($urandom_range(0, 3) != 0)
					idle_gap($urandom_range(1, 12));
			end
			idle_gap(0);
			// sender pauses until everything has come back
			drain_pipe();
		end

		drain_pipe();
		if (fail_count == 0 && pending_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
